// ===== hw/rtl/fvpw_pkg.sv =====
// Shared types, codes and service-table functions for the frame validator.
// No dependencies; every other file in hw/rtl imports this package.
package fvpw_pkg;

	// Header magic and length
	localparam logic [7:0] MAGIC0       = 8'h10;
	localparam logic [7:0] MAGIC1       = 8'h81;
	localparam logic [3:0] HEADER_BYTES = 4'd10;

	// Walk phase; the value doubles as the byte role of the byte seen in it
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_SERVICE = 3'd1,
		PH_COUNT1  = 3'd2,
		PH_CODE    = 3'd3,
		PH_LENGTH  = 3'd4,
		PH_DATA    = 3'd5,
		PH_COUNT2  = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	// Access classes
	localparam logic [2:0] ACC_NONE         = 3'd0;
	localparam logic [2:0] ACC_SET          = 3'd1;
	localparam logic [2:0] ACC_SET_RES      = 3'd2;
	localparam logic [2:0] ACC_GET          = 3'd3;
	localparam logic [2:0] ACC_GET_RES      = 3'd4;
	localparam logic [2:0] ACC_ANNOUNCE     = 3'd5;
	localparam logic [2:0] ACC_ANNOUNCE_RES = 3'd6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0] byte_role;
		logic [7:0] prop_index;
		logic [2:0] access_class;
		logic [7:0] byte_echo;
		logic       frame_done;
		logic       frame_valid;
	} out_item_t;

	// Standard service codes
	function automatic logic is_service(input logic [7:0] c);
		logic r;
		case (c) inside
			8'h60, 8'h61, 8'h62, 8'h63, 8'h6E,
			8'h71, 8'h72, 8'h73, 8'h74, 8'h7A, 8'h7E,
			8'h50, 8'h51, 8'h52, 8'h53, 8'h5E: r = 1'b1;
			default:                           r = 1'b0;
		endcase
		return r;
	endfunction

	// Combined set/get services carry a second list
	function automatic logic is_combined(input logic [7:0] c);
		return (c == 8'h6E) || (c == 8'h7E) || (c == 8'h5E);
	endfunction

	function automatic logic [2:0] class_of(input logic [7:0] c, input logic second);
		logic [2:0] r;
		case (c) inside
			8'h60, 8'h61:                r = ACC_SET;
			8'h71, 8'h50, 8'h51:         r = ACC_SET_RES;
			8'h62:                       r = ACC_GET;
			8'h72, 8'h52:                r = ACC_GET_RES;
			8'h63, 8'h53, 8'h73, 8'h74:  r = ACC_ANNOUNCE;
			8'h7A:                       r = ACC_ANNOUNCE_RES;
			8'h6E, 8'h7E, 8'h5E:         r = second ? ACC_GET : ACC_SET;
			default:                     r = ACC_NONE;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/fvpw_walker.sv =====
// Frame walk state and per-byte tagging logic.
// Depends on fvpw_pkg; the state advances once per item moved to the result register.
module fvpw_walker
	import fvpw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_en,
	input  in_item_t  item,
	output out_item_t result
);

	logic [3:0] header_pos_q, header_pos_d;
	phase_t     phase_q, phase_d;
	logic [7:0] service_code_q, service_code_d;
	logic [7:0] props_left_q, props_left_d;
	logic [7:0] data_left_q, data_left_d;
	logic [7:0] prop_counter_q, prop_counter_d;
	logic       in_second_q, in_second_d;
	logic       error_seen_q, error_seen_d;

	// Compute the tag of this byte and the next walk state
	always_comb begin
		logic [7:0] b;
		logic [7:0] pl_dec;
		logic [7:0] dl_dec;
		logic       finish;
		logic [2:0] acc;
		logic [7:0] idx;
		logic [3:0] hp_inc;

		b      = item.in_byte;
		pl_dec = props_left_q - 8'd1;
		dl_dec = data_left_q - 8'd1;
		finish = 1'b0;
		acc    = ACC_NONE;
		idx    = 8'd0;
		hp_inc = header_pos_q + 4'd1;

		header_pos_d   = header_pos_q;
		phase_d        = phase_q;
		service_code_d = service_code_q;
		props_left_d   = props_left_q;
		data_left_d    = data_left_q;
		prop_counter_d = prop_counter_q;
		in_second_d    = in_second_q;
		error_seen_d   = error_seen_q;

		case (phase_q)
			PH_HEADER: begin
				if (header_pos_q == 4'd0 && b != MAGIC0) error_seen_d = 1'b1;
				if (header_pos_q == 4'd1 && b != MAGIC1) error_seen_d = 1'b1;
				header_pos_d = hp_inc;
				if (hp_inc >= HEADER_BYTES) begin
					header_pos_d = HEADER_BYTES;
					phase_d      = PH_SERVICE;
				end
			end
			PH_SERVICE: begin
				service_code_d = b;
				if (!is_service(b)) error_seen_d = 1'b1;
				acc     = class_of(b, 1'b0);
				phase_d = PH_COUNT1;
			end
			PH_COUNT1: begin
				acc            = class_of(service_code_q, 1'b0);
				props_left_d   = b;
				prop_counter_d = 8'd0;
				if (b == 8'd0) begin
					error_seen_d = 1'b1;
					phase_d      = PH_DONE;
				end else begin
					phase_d = PH_CODE;
				end
			end
			PH_CODE: begin
				idx     = prop_counter_q;
				acc     = class_of(service_code_q, in_second_q);
				phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				idx         = prop_counter_q;
				acc         = class_of(service_code_q, in_second_q);
				data_left_d = b;
				if (b == 8'd0) finish = 1'b1;
				else phase_d = PH_DATA;
			end
			PH_DATA: begin
				idx         = prop_counter_q;
				acc         = class_of(service_code_q, in_second_q);
				data_left_d = dl_dec;
				if (dl_dec == 8'd0) finish = 1'b1;
			end
			PH_COUNT2: begin
				acc            = class_of(service_code_q, 1'b1);
				in_second_d    = 1'b1;
				props_left_d   = b;
				prop_counter_d = 8'd0;
				phase_d        = (b == 8'd0) ? PH_DONE : PH_CODE;
			end
			default: begin
				error_seen_d = 1'b1;
			end
		endcase

		// Close the current property
		if (finish) begin
			prop_counter_d = prop_counter_q + 8'd1;
			props_left_d   = pl_dec;
			if (pl_dec == 8'd0) begin
				if (is_combined(service_code_q) && !in_second_q) phase_d = PH_COUNT2;
				else phase_d = PH_DONE;
			end else begin
				phase_d = PH_CODE;
			end
		end

		result.byte_role    = phase_q;
		result.prop_index   = idx;
		result.access_class = acc;
		result.byte_echo    = b;
		result.frame_done   = item.frame_end;
		result.frame_valid  = item.frame_end && !error_seen_d && (phase_d == PH_DONE);
	end

	// Advance the walk; drop back to reset state after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q   <= 4'd0;
			phase_q        <= PH_HEADER;
			service_code_q <= 8'd0;
			props_left_q   <= 8'd0;
			data_left_q    <= 8'd0;
			prop_counter_q <= 8'd0;
			in_second_q    <= 1'b0;
			error_seen_q   <= 1'b0;
		end else if (step_en) begin
			if (item.frame_end) begin
				header_pos_q   <= 4'd0;
				phase_q        <= PH_HEADER;
				service_code_q <= 8'd0;
				props_left_q   <= 8'd0;
				data_left_q    <= 8'd0;
				prop_counter_q <= 8'd0;
				in_second_q    <= 1'b0;
				error_seen_q   <= 1'b0;
			end else begin
				header_pos_q   <= header_pos_d;
				phase_q        <= phase_d;
				service_code_q <= service_code_d;
				props_left_q   <= props_left_d;
				data_left_q    <= data_left_d;
				prop_counter_q <= prop_counter_d;
				in_second_q    <= in_second_d;
				error_seen_q   <= error_seen_d;
			end
		end
	end

endmodule

// ===== hw/rtl/frame_validator_property_walker.sv =====
// Frame validator and property walker, top level: input register, walker, result register.
// Items move from the input register to the result register; throughput is 1 item per
// cycle unless dst_ready stalls, set by the single walker state update per result load.
// Reset (arst_n low, asynchronous): both pipeline stages empty, walker at frame start.
// Depends on fvpw_pkg and fvpw_walker.
module frame_validator_property_walker
	import fvpw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  in_item_t  src_item,
	output logic      dst_valid,
	input  logic      dst_ready,
	output out_item_t dst_item
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t walk_tag;
	logic      adv_s2;
	logic      adv_s1;

	// Result register empties or hands off; input register follows
	assign adv_s2    = !dst_valid || dst_ready;
	assign adv_s1    = valid_s1 && adv_s2;
	assign src_ready = !valid_s1 || adv_s2;

	// Hold the accepted item in the input register until it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) item_s1 <= src_item;
	end

	fvpw_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv_s1),
		.item    (item_s1),
		.result  (walk_tag)
	);

	// Register the tagged item toward the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (adv_s2) begin
			dst_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) dst_item <= walk_tag;
	end

endmodule
